/* hdl/vie_pkg.sv */
// ----------------------------------------------------------------------------
// vie_pkg
// Shared types, opcodes and float helpers for the instruction execute core.
// ----------------------------------------------------------------------------
package vie_pkg;

  typedef enum logic [1:0] {
    FUNC_EXEC  = 2'd0,
    FUNC_MEMWR = 2'd1,
    FUNC_MEMRD = 2'd2,
    FUNC_REGRD = 2'd3
  } func_e;

  localparam logic [3:0] OP_LOAD  = 4'h1;
  localparam logic [3:0] OP_LDI   = 4'h2;
  localparam logic [3:0] OP_STORE = 4'h3;
  localparam logic [3:0] OP_MOVE  = 4'h4;
  localparam logic [3:0] OP_ADDI  = 4'h5;
  localparam logic [3:0] OP_ADDF  = 4'h6;
  localparam logic [3:0] OP_OR    = 4'h7;
  localparam logic [3:0] OP_AND   = 4'h8;
  localparam logic [3:0] OP_XOR   = 4'h9;
  localparam logic [3:0] OP_ROT   = 4'hA;
  localparam logic [3:0] OP_JEQ   = 4'hB;
  localparam logic [3:0] OP_JGT   = 4'hD;

  // request passed from front to back
  typedef struct packed {
    logic [1:0]  func;
    logic [15:0] instruction;
    logic [7:0]  address;
    logic [7:0]  write_data;
  } req_t;

  typedef struct packed {
    logic       unsupported_opcode;
    logic       float_overflow;
    logic [7:0] read_data;
    logic [7:0] jump_target;
    logic       jump_taken;
  } rsp_t;

  // signed value in units of 2^-8, magnitude up to 15*128
  function automatic logic signed [12:0] float_decode(input logic [7:0] b);
    logic [11:0] mag;
    mag = 12'(b[3:0]) << b[6:4];
    return b[7] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  endfunction

  // returns {overflow, byte}
  function automatic logic [8:0] float_encode(input logic signed [12:0] v);
    logic [12:0] mag;
    logic [3:0]  p;
    logic [7:0]  res;
    logic        ovf;
    mag = v[12] ? 13'(-v) : 13'(v);
    p   = 4'd0;
    for (int i = 1; i < 13; i++) begin
      if (mag[i]) p = 4'(i);
    end
    ovf = 1'b0;
    res = 8'h00;
    if (mag == 13'd0 || p < 4'd3) begin
      res = 8'h00;
    end else if (p > 4'd10) begin
      ovf = 1'b1;
    end else begin
      res = {v[12], 3'(p - 4'd3), 4'(mag >> (p - 4'd3))};
    end
    return {ovf, res};
  endfunction

endpackage

/* hdl/vie_ram.sv */
// ----------------------------------------------------------------------------
// vie_ram
// Generic single-port-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module vie_ram #(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

/* hdl/vie_front.sv */
// ----------------------------------------------------------------------------
// vie_front
// Accepts requests into a two-entry queue feeding the execute back end.
// ----------------------------------------------------------------------------
module vie_front
  import vie_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  req_t in_req_i,
  output logic q_valid_o,
  input  logic q_ready_i,
  output req_t q_req_o
);
  req_t       buf_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       push, pop;

  assign in_ready_o = cnt_q != 2'd2;
  assign q_valid_o  = cnt_q != 2'd0;
  assign q_req_o    = buf_q[rp_q];
  assign push       = in_valid_i && in_ready_o;
  assign pop        = q_valid_o && q_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      buf_q[wp_q] <= in_req_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (pop)  rp_q <= ~rp_q;
      cnt_q <= 2'(cnt_q + 2'(push) - 2'(pop));
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3) else $error("queue count out of range");
  a_full_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd2 && !pop) |=> cnt_q == 2'd2) else $error("queue lost entry");
  a_empty_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd0 && push) |=> q_valid_o) else $error("push not visible");
`endif
endmodule

/* hdl/vie_back.sv */
// ----------------------------------------------------------------------------
// vie_back
// Execute back end: register file in flops, memory in RAM. Read then write.
// ----------------------------------------------------------------------------
module vie_back
  import vie_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic q_valid_i,
  output logic q_ready_o,
  input  req_t q_req_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output rsp_t out_rsp_o
);
  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_CLEAR = 3'b010,
    ST_EXEC  = 3'b100
  } state_e;

  state_e      state_q, state_d;
  logic [7:0]  clr_q;
  req_t        cur_q;
  logic [7:0]  rf_q [16];
  logic        ovalid_q;
  rsp_t        orsp_q;
  logic        mem_we;
  logic [7:0]  mem_wa, mem_wd, mem_ra, mem_rd;
  logic        mem_fwd_q;
  logic [7:0]  mem_fwd_data_q, mem_data;
  logic [3:0]  op, r, s, t;
  logic [7:0]  a, b, rv, xy;
  logic [8:0]  fenc;
  logic        rf_we;
  logic [3:0]  rf_wa;
  logic [7:0]  rf_wd;
  rsp_t        rsp;
  logic        take, done;

  vie_ram #(.Width(8), .Depth(256)) u_mem (
    .clk_i, .we_i(mem_we), .waddr_i(mem_wa), .wdata_i(mem_wd),
    .raddr_i(mem_ra), .rdata_o(mem_rd));

  assign op = cur_q.instruction[15:12];
  assign r  = cur_q.instruction[11:8];
  assign s  = cur_q.instruction[7:4];
  assign t  = cur_q.instruction[3:0];
  assign xy = cur_q.instruction[7:0];
  assign a  = rf_q[s];
  assign b  = rf_q[t];
  assign rv = rf_q[r];
  assign fenc = float_encode(13'(float_decode(a) + float_decode(b)));

  assign done      = state_q == ST_EXEC && (!ovalid_q || out_ready_i);
  assign q_ready_o = state_q == ST_IDLE || done;
  assign take      = q_valid_i && q_ready_o;
  // re-read the current address while stalled
  assign mem_ra    = take ? (q_req_i.func == FUNC_EXEC ? q_req_i.instruction[7:0]
                                                       : q_req_i.address)
                   : (state_q == ST_EXEC) ? (cur_q.func == FUNC_EXEC ? xy
                                                                     : cur_q.address)
                   : 8'h00;
  // write and read of one address at the same edge
  assign mem_data  = mem_fwd_q ? mem_fwd_data_q : mem_rd;

  always_comb begin
    rsp    = '0;
    rf_we  = 1'b0;
    rf_wa  = r;
    rf_wd  = 8'h00;
    mem_we = 1'b0;
    mem_wa = xy;
    mem_wd = rv;
    unique case (cur_q.func)
      FUNC_MEMWR: begin
        mem_we = done;
        mem_wa = cur_q.address;
        mem_wd = cur_q.write_data;
      end
      FUNC_MEMRD: rsp.read_data = mem_data;
      FUNC_REGRD: rsp.read_data = rf_q[cur_q.address[3:0]];
      default: begin
        case (op)
          OP_LOAD:  begin rf_we = 1'b1; rf_wd = mem_data; end
          OP_LDI:   begin rf_we = 1'b1; rf_wd = xy; end
          OP_STORE: mem_we = done;
          OP_MOVE:  begin rf_we = 1'b1; rf_wa = t; rf_wd = a; end
          OP_ADDI:  begin rf_we = 1'b1; rf_wd = 8'(a + b); end
          OP_ADDF:  begin
            rsp.float_overflow = fenc[8];
            rf_we = !fenc[8];
            rf_wd = fenc[7:0];
          end
          OP_OR:    begin rf_we = 1'b1; rf_wd = a | b; end
          OP_AND:   begin rf_we = 1'b1; rf_wd = a & b; end
          OP_XOR:   begin rf_we = 1'b1; rf_wd = a ^ b; end
          OP_ROT:   begin
            rf_we = 1'b1;
            rf_wd = 8'({rv, rv} >> t[2:0]);
          end
          OP_JEQ: if (rv == rf_q[0]) begin
            rsp.jump_taken = 1'b1; rsp.jump_target = xy;
          end
          OP_JGT: if ($signed(rv) > $signed(rf_q[0])) begin
            rsp.jump_taken = 1'b1; rsp.jump_target = xy;
          end
          default: rsp.unsupported_opcode = 1'b1;
        endcase
      end
    endcase
    if (state_q == ST_CLEAR) begin
      mem_we = 1'b1;
      mem_wa = clr_q;
      mem_wd = 8'h00;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: if (clr_q == 8'hFF) state_d = ST_IDLE;
      ST_IDLE:  if (take) state_d = ST_EXEC;
      ST_EXEC:  if (done) state_d = take ? ST_EXEC : ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (take) cur_q <= q_req_i;
    if (done) orsp_q <= rsp;
    mem_fwd_data_q <= mem_wd;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      clr_q     <= 8'h00;
      ovalid_q  <= 1'b0;
      mem_fwd_q <= 1'b0;
      for (int i = 0; i < 16; i++) rf_q[i] <= 8'h00;
    end else begin
      state_q   <= state_d;
      mem_fwd_q <= mem_we && (mem_wa == mem_ra);
      if (state_q == ST_CLEAR) clr_q <= 8'(clr_q + 8'd1);
      if (done) ovalid_q <= 1'b1;
      else if (out_ready_i) ovalid_q <= 1'b0;
      if (done && rf_we && cur_q.func == FUNC_EXEC) rf_q[rf_wa] <= rf_wd;
    end
  end

  assign out_valid_o = ovalid_q;
  assign out_rsp_o   = orsp_q;

`ifndef SYNTHESIS
  a_clear_no_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_CLEAR |-> !take) else $error("request taken during clear");
  a_done_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done |=> out_valid_o) else $error("result not presented");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> $stable(out_rsp_o)) else $error("result changed");
`endif
endmodule

/* hdl/vole_instruction_execute_core.sv */
// ----------------------------------------------------------------------------
// vole_instruction_execute_core
// Executes Vole instructions and host memory/register accesses.
// ----------------------------------------------------------------------------
// Path to a valid result: the request queue, then the registered RAM read, then the output register.
// Throughput: one request per cycle; output stalls hold the back end.
// Reset: registers clear at once; a pass over all 256 addresses clears memory, and
// the back end takes no request until it ends.
module vole_instruction_execute_core
  import vie_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // instruction, address, write_data
  input  logic [1:0]  s_axis_tuser,  // func
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata   // jump_taken, jump_target, read_data,
                                     // float_overflow, unsupported_opcode
);
  req_t in_req, q_req;
  rsp_t rsp;
  logic q_valid, q_ready;

  assign in_req = '{func: s_axis_tuser, instruction: s_axis_tdata[15:0],
                    address: s_axis_tdata[23:16], write_data: s_axis_tdata[31:24]};

  vie_front u_front (
    .clk_i, .rst_ni, .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .in_req_i(in_req), .q_valid_o(q_valid), .q_ready_i(q_ready), .q_req_o(q_req));

  vie_back u_back (
    .clk_i, .rst_ni, .q_valid_i(q_valid), .q_ready_o(q_ready), .q_req_i(q_req),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready), .out_rsp_o(rsp));

  assign m_axis_tdata = {5'd0, rsp.unsupported_opcode, rsp.float_overflow,
                         rsp.read_data, rsp.jump_target, rsp.jump_taken};
endmodule
